// ===== hw/rtl/lrd_pkg.sv =====
// package for the local reachability density block
// holds the shared field widths, opcode codes, queue entry type and back-end states
// no dependencies
package lrd_pkg;

  // field widths fixed by the interface
  localparam int unsigned POINT_W = 10;
  localparam int unsigned DIST_W  = 32;
  localparam int unsigned SUM_W   = 38;
  localparam int unsigned K_W     = 7;

  // configuration register map
  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0] REG_NEIGHBOR_COUNT = 1'b0;

  // job queue between front and back end
  localparam int unsigned FIFO_DEPTH = 2;

  // input opcodes
  typedef enum logic [0:0] {
    OP_KDIST_WRITE = 1'b0,
    OP_ACCUMULATE  = 1'b1
  } lrd_op_e;

  // one finished query waiting for its division
  typedef struct packed {
    logic [POINT_W-1:0] point;
    logic [SUM_W-1:0]   sum;
    logic [K_W-1:0]     k;
  } lrd_job_t;

  // back-end divider states
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_RUN  = 2'd1,
    BK_DONE = 2'd2
  } lrd_back_state_e;

endpackage

// ===== hw/rtl/lof_reachability_density.sv =====
// local reachability density block: input channel, result channel, apb register port
// file holds the top level; depends on lrd_pkg, lrd_front, lrd_fifo and lrd_back
//
// Usage:
//   input channel (in_valid_i / in_stall_o) carries one transaction per item:
//   opcode 0 stores a k-distance table entry, opcode 1 adds one neighbor term
//   max(k-distance, distance) to the running sum of the current query point.
//   After neighbor_count terms one result leaves on the output channel
//   (out_valid_o / out_stall_i): the point, k / sum in unsigned Q0.32
//   (saturated), and a flag for a zero sum.
//   A table write does not stall the input; a neighbor term stalls it while
//   the table is read and the term is then added. The divider in the back end
//   produces one quotient bit a cycle; a saturated or zero sum skips the
//   division. The back end takes a new job only after its last result is
//   loaded into the output register; a two-entry job queue lets the front end
//   continue summing the next queries meanwhile and stalls it only when full.
//   A result waiting in the output register while out_stall_i is high does
//   not block the divider from starting the next job.
//   Reset clears the sum, the term count and all handshake state and sets
//   neighbor_count to 1; table contents are undefined until written.
//   neighbor_count (byte address 0) must be written only while the block is idle; the block does not enforce this.
module lof_reachability_density
  import lrd_pkg::*;
#(
  parameter int unsigned MAX_POINTS    = 1024,
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [POINT_W-1:0] point_index_i,
  input  logic [POINT_W-1:0] neighbor_index_i,
  input  logic [DIST_W-1:0]  distance_value_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [POINT_W-1:0] result_point_o,
  output logic [DIST_W-1:0]  density_score_o,
  output logic               zero_sum_flag_o,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [K_W-1:0] neighbor_count_q;
  logic           reg_sel;
  logic           push;
  lrd_job_t       push_data;
  logic           fifo_full;
  logic           pop;
  logic           job_valid;
  lrd_job_t       job;

  // register decode, one word per register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_NEIGHBOR_COUNT);
  assign prdata  = reg_sel ? 32'(neighbor_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neighbor_count_q <= K_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      neighbor_count_q <= pwdata[K_W-1:0];
    end
  end

  // front end
  lrd_front #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .point_index_i    (point_index_i),
    .neighbor_index_i (neighbor_index_i),
    .distance_value_i (distance_value_i),
    .neighbor_count_i (neighbor_count_q),
    .push_o           (push),
    .push_data_o      (push_data),
    .full_i           (fifo_full)
  );

  // job queue
  lrd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (job_valid),
    .pop_data_o  (job)
  );

  // back end
  lrd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (job_valid),
    .job_i           (job),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .result_point_o  (result_point_o),
    .density_score_o (density_score_o),
    .zero_sum_flag_o (zero_sum_flag_o)
  );

endmodule

// ===== hw/rtl/lrd_ram.sv =====
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module lrd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // storage write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/lrd_fifo.sv =====
// short job queue between the accumulating front end and the dividing back end
// depends on lrd_pkg
module lrd_fifo
  import lrd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lrd_job_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output lrd_job_t pop_data_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  lrd_job_t         entry_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o     = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = entry_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/lrd_front.sv =====
// front end: takes transactions, keeps the k-distance table, sums reachability terms
// depends on lrd_pkg and lrd_ram; pushes finished queries into lrd_fifo
module lrd_front
  import lrd_pkg::*;
#(
  parameter int unsigned MAX_POINTS    = 1024,
  parameter int unsigned MAX_NEIGHBORS = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               opcode_i,
  input  logic [POINT_W-1:0] point_index_i,
  input  logic [POINT_W-1:0] neighbor_index_i,
  input  logic [DIST_W-1:0]  distance_value_i,
  input  logic [K_W-1:0]     neighbor_count_i,
  output logic               push_o,
  output lrd_job_t           push_data_o,
  input  logic               full_i
);

  localparam int unsigned AW = $clog2(MAX_POINTS);

  logic               busy_q;
  logic [POINT_W-1:0] pidx_q;
  logic [DIST_W-1:0]  dist_q;
  logic               in_range_q;
  logic [SUM_W-1:0]   sum_q;
  logic [K_W-1:0]     terms_q;

  logic               accept;
  logic               in_range;
  logic [AW-1:0]      addr;
  logic               ram_we;
  logic               ram_re;
  logic [DIST_W-1:0]  ram_rdata;
  logic [DIST_W-1:0]  kd;
  logic [DIST_W-1:0]  reach;
  logic [SUM_W:0]     sum_wide;
  logic [SUM_W-1:0]   sum_new;
  logic [K_W-1:0]     terms_new;
  logic [K_W-1:0]     k_eff;
  logic               last_term;
  logic               retire;

  // transaction accept and table addressing
  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign in_range   = (32'(neighbor_index_i) < 32'(MAX_POINTS));
  assign addr       = AW'(neighbor_index_i);
  assign ram_we     = accept && (opcode_i == OP_KDIST_WRITE) && in_range;
  assign ram_re     = accept && (opcode_i == OP_ACCUMULATE);

  lrd_ram #(
    .WIDTH (DIST_W),
    .DEPTH (MAX_POINTS)
  ) u_kdist_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (distance_value_i),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // effective neighbor count, zero acts as one and clamps at the maximum
  always_comb begin
    k_eff = neighbor_count_i;
    if (neighbor_count_i == '0) begin
      k_eff = K_W'(1);
    end else if (32'(neighbor_count_i) > 32'(MAX_NEIGHBORS)) begin
      k_eff = K_W'(MAX_NEIGHBORS);
    end
  end

  // reachability term and saturating sum
  assign kd        = in_range_q ? ram_rdata : '0;
  assign reach     = (kd >= dist_q) ? kd : dist_q;
  assign sum_wide  = {1'b0, sum_q} + (SUM_W + 1)'(reach);
  assign sum_new   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
  assign terms_new = terms_q + 1'b1;
  assign last_term = (terms_new >= k_eff);
  assign retire    = busy_q && !(last_term && full_i);

  assign push_o            = busy_q && last_term && !full_i;
  assign push_data_o.point = pidx_q;
  assign push_data_o.sum   = sum_new;
  assign push_data_o.k     = k_eff;

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      sum_q   <= '0;
      terms_q <= '0;
    end else begin
      if (ram_re) begin
        busy_q <= 1'b1;
      end else if (retire) begin
        busy_q <= 1'b0;
      end
      if (retire) begin
        sum_q   <= last_term ? '0 : sum_new;
        terms_q <= last_term ? '0 : terms_new;
      end
    end
  end

  // operands of the term in flight
  always_ff @(posedge clk_i) begin
    if (ram_re) begin
      pidx_q     <= point_index_i;
      dist_q     <= distance_value_i;
      in_range_q <= in_range;
    end
  end

endmodule

// ===== hw/rtl/lrd_back.sv =====
// back end: divides k * 2^32 by the reachability sum, one quotient bit per cycle
// depends on lrd_pkg; pops jobs from lrd_fifo and drives the result channel
module lrd_back
  import lrd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  lrd_job_t           job_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [POINT_W-1:0] result_point_o,
  output logic [DIST_W-1:0]  density_score_o,
  output logic               zero_sum_flag_o
);

  localparam int unsigned CNT_W = $clog2(DIST_W);

  lrd_back_state_e state_q, state_d;

  logic [SUM_W:0]     rem_q;
  logic [SUM_W-1:0]   den_q;
  logic [DIST_W-1:0]  quo_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [POINT_W-1:0] point_q;
  logic               zero_q;

  logic               out_valid_q;
  logic [POINT_W-1:0] out_point_q;
  logic [DIST_W-1:0]  out_score_q;
  logic               out_zero_q;

  logic               out_free;
  logic               out_load;
  logic               job_sat;
  logic [SUM_W:0]     rem_shift;
  logic               q_bit;
  logic [SUM_W:0]     rem_next;

  assign out_free = !out_valid_q || !out_stall_i;
  // quotient reaches 2^32 exactly when the sum does not exceed k
  assign job_sat  = (job_i.sum <= SUM_W'(job_i.k));

  // one restoring division step
  assign rem_shift = {rem_q[SUM_W-1:0], 1'b0};
  assign q_bit     = (rem_shift >= {1'b0, den_q});
  assign rem_next  = q_bit ? (rem_shift - {1'b0, den_q}) : rem_shift;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_sat ? BK_DONE : BK_RUN;
        end
      end
      BK_RUN: begin
        if (cnt_q == CNT_W'(DIST_W - 1)) begin
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop_o    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      BK_IDLE: pop_o    = job_valid_i;
      BK_RUN:  pop_o    = 1'b0;
      BK_DONE: out_load = out_free;
      default: begin
        pop_o    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      point_q <= job_i.point;
      den_q   <= job_i.sum;
      zero_q  <= (job_i.sum == '0);
      rem_q   <= (SUM_W + 1)'(job_i.k);
      quo_q   <= job_sat ? '1 : '0;
      cnt_q   <= '0;
    end else if (state_q == BK_RUN) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[DIST_W-2:0], q_bit};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_point_q <= point_q;
      out_score_q <= quo_q;
      out_zero_q  <= zero_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_point_o  = out_point_q;
  assign density_score_o = out_score_q;
  assign zero_sum_flag_o = out_zero_q;

endmodule

// ===== tb/sv/lof_reachability_density_tb.sv =====
`timescale 1ns / 1ps
// testbench for lof_reachability_density: directed and random neighbor streams, apb register
// writes between phases, results checked against a density predictor in a scoreboard class
// depends on lrd_pkg and the lof_reachability_density rtl
module lof_reachability_density_tb;
  import lrd_pkg::*;

  localparam int unsigned TABLE_DEPTH   = 1024;
  localparam int unsigned K_LIMIT       = 64;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned PHASE_ITEMS   = 72;
  localparam int unsigned NUM_PHASES    = 12;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam logic [SUM_W-1:0]  SUM_SAT   = '1;
  localparam logic [DIST_W-1:0] SCORE_SAT = '1;
  localparam logic [K_W-1:0] PHASE_K [NUM_PHASES] = '{
    7'd2, 7'd1, 7'd64, 7'd0, 7'd127, 7'd8, 7'd3, 7'd65, 7'd1, 7'd16, 7'd4, 7'd5
  };

  typedef struct {
    logic [POINT_W-1:0] point;
    logic [DIST_W-1:0]  score;
    logic               zero_sum;
  } density_t;

  // predicts densities and holds the ones still owed by the block
  class density_scoreboard;
    logic [DIST_W-1:0] kdist [TABLE_DEPTH];
    logic [SUM_W-1:0]  reach_sum;
    int unsigned       terms_seen;
    logic [K_W-1:0]    neighbor_count;
    density_t          expected_scores [$];
    int unsigned       mismatches;

    function new();
      foreach (kdist[i]) kdist[i] = '0;
      reach_sum      = '0;
      terms_seen     = 0;
      neighbor_count = K_W'(1);
      mismatches     = 0;
    endfunction

    // zero acts as one, anything above the neighbor limit is clamped
    function int unsigned effective_k();
      int unsigned k;
      k = neighbor_count;
      if (k == 0) k = 1;
      if (k > K_LIMIT) k = K_LIMIT;
      return k;
    endfunction

    function int unsigned terms_left();
      return (terms_seen < effective_k()) ? effective_k() - terms_seen : 1;
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // accepted input transaction
    function void note_input(lrd_op_e op, logic [POINT_W-1:0] pidx,
                             logic [POINT_W-1:0] nidx, logic [DIST_W-1:0] distance);
      logic [DIST_W-1:0] reach;
      logic [SUM_W:0]    wide_sum;
      logic [63:0]       quotient;
      density_t          res;
      int unsigned       k;
      if (op == OP_KDIST_WRITE) begin
        kdist[nidx] = distance;
        return;
      end
      // reachability distance, saturating sum
      reach     = (kdist[nidx] >= distance) ? kdist[nidx] : distance;
      wide_sum  = {1'b0, reach_sum} + (SUM_W+1)'(reach);
      reach_sum = wide_sum[SUM_W] ? SUM_SAT : wide_sum[SUM_W-1:0];
      terms_seen++;
      k = effective_k();
      if (terms_seen < k) return;
      // k / sum in q0.32, saturated
      res.point = pidx;
      if (reach_sum == '0) begin
        res.score    = SCORE_SAT;
        res.zero_sum = 1'b1;
      end else begin
        quotient     = (64'(k) << 32) / 64'(reach_sum);
        res.score    = (quotient > 64'(SCORE_SAT)) ? SCORE_SAT : quotient[DIST_W-1:0];
        res.zero_sum = 1'b0;
      end
      expected_scores.push_back(res);
      reach_sum  = '0;
      terms_seen = 0;
    endfunction

    // accepted result transaction
    function void check_result(logic [POINT_W-1:0] point, logic [DIST_W-1:0] score,
                               logic zero_sum);
      density_t want;
      if (expected_scores.size() == 0) begin
        flag_mismatch($sformatf("unexpected result point %0d score %h flag %0b",
                                point, score, zero_sum));
        return;
      end
      want = expected_scores.pop_front();
      if (point !== want.point || score !== want.score || zero_sum !== want.zero_sum) begin
        flag_mismatch($sformatf("point %0d/%0d score %h/%h flag %0b/%0b (expected/actual)",
                                want.point, point, want.score, score, want.zero_sum, zero_sum));
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               opcode = 1'b0;
  logic [POINT_W-1:0] point_index = '0;
  logic [POINT_W-1:0] neighbor_index = '0;
  logic [DIST_W-1:0]  distance_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [POINT_W-1:0] result_point;
  logic [DIST_W-1:0]  density_score;
  logic               zero_sum_flag;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  int unsigned tx_idle_pct = 14;
  int unsigned rx_stall_pct = 48;
  logic        rx_hold = 1'b0;
  int unsigned items_sent = 0;

  bit                 written [TABLE_DEPTH];
  logic [POINT_W-1:0] written_list [$];

  density_scoreboard tracker = new();

  always #4 clk = ~clk;

  lof_reachability_density i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .opcode_i         (opcode),
    .point_index_i    (point_index),
    .neighbor_index_i (neighbor_index),
    .distance_value_i (distance_value),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .result_point_o   (result_point),
    .density_score_o  (density_score),
    .zero_sum_flag_o  (zero_sum_flag),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // result side: check accepted transactions, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      tracker.check_result(result_point, density_score, zero_sum_flag);
    end
    out_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
  end

  // watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DIST_W-1:0] random_distance();
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return DIST_W'($urandom_range(32'h0004_0000));
      2:       return '0;
      default: return $urandom & 32'h00FF_FFFF;
    endcase
  endfunction

  function automatic logic [POINT_W-1:0] pick_written();
    return written_list[$urandom_range(written_list.size() - 1)];
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_item(input lrd_op_e op, input logic [POINT_W-1:0] pidx,
                           input logic [POINT_W-1:0] nidx,
                           input logic [DIST_W-1:0] distance);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid       <= 1'b1;
    opcode         <= op;
    point_index    <= pidx;
    neighbor_index <= nidx;
    distance_value <= distance;
    do @(posedge clk); while (in_stall);
    tracker.note_input(op, pidx, nidx, distance);
    items_sent++;
  endtask

  task automatic write_kdist(input logic [POINT_W-1:0] idx, input logic [DIST_W-1:0] value);
    send_item(OP_KDIST_WRITE, POINT_W'($urandom_range(TABLE_DEPTH - 1)), idx, value);
    if (!written[idx]) begin
      written[idx] = 1'b1;
      written_list.push_back(idx);
    end
  endtask

  // neighbor terms for one query point, sometimes cut short or mixed with table writes
  task automatic send_query(input logic [POINT_W-1:0] pidx);
    int unsigned count;
    count = tracker.terms_left();
    if ($urandom_range(9) == 0) count = $urandom_range(count, 1);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(7) == 0) begin
        write_kdist(POINT_W'($urandom_range(TABLE_DEPTH - 1)), random_distance());
      end
      send_item(OP_ACCUMULATE, pidx, pick_written(), random_distance());
    end
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < n) begin
      case ($urandom_range(9))
        0, 1:    write_kdist(POINT_W'($urandom_range(TABLE_DEPTH - 1)), random_distance());
        2:       send_item(OP_ACCUMULATE, POINT_W'($urandom_range(TABLE_DEPTH - 1)),
                           pick_written(), random_distance());
        default: send_query(POINT_W'($urandom_range(TABLE_DEPTH - 1)));
      endcase
    end
  endtask

  // drain all owed results, then let any term still in flight finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (tracker.expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write of neighbor_count, then read back
  task automatic write_neighbor_count(input logic [K_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_NEIGHBOR_COUNT, 2'b00});
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    tracker.neighbor_count = value;
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value)) begin
      tracker.flag_mismatch($sformatf("neighbor_count read %h/%h (expected/actual)",
                                      32'(value), prdata));
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic hold_receiver();
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  endtask

  task automatic run_directed();
    // zero table entry and zero distance give a zero sum
    write_kdist(10'd0, 32'h0000_0000);
    send_item(OP_ACCUMULATE, 10'd0, 10'd0, 32'h0000_0000);
    // largest table value wins over zero distance
    write_kdist(10'd1023, 32'hFFFF_FFFF);
    send_item(OP_ACCUMULATE, 10'd1023, 10'd1023, 32'h0000_0000);
    // largest distance wins over zero table value
    send_item(OP_ACCUMULATE, 10'h2AA, 10'd0, 32'hFFFF_FFFF);
    // sum of one lsb saturates the score
    write_kdist(10'h155, 32'h0000_0001);
    send_item(OP_ACCUMULATE, 10'h155, 10'h155, 32'h0000_0000);
    write_kdist(10'h2AA, 32'h0001_8000);
    send_item(OP_ACCUMULATE, 10'h0F0, 10'h2AA, 32'h0001_0000);
    // count of zero behaves as one
    wait_idle();
    write_neighbor_count(7'd0);
    send_item(OP_ACCUMULATE, 10'h30F, 10'h2AA, 32'h0002_0000);
    // count lowered to the number of terms already summed
    wait_idle();
    write_neighbor_count(7'd3);
    send_item(OP_ACCUMULATE, 10'd7, 10'd0, 32'h0000_4000);
    send_item(OP_ACCUMULATE, 10'd7, 10'd1023, 32'h0001_0000);
    wait_idle();
    write_neighbor_count(7'd2);
    send_item(OP_ACCUMULATE, 10'd7, 10'h155, 32'h0000_0001);
  endtask

  // main sequence
  initial begin : stimulus
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    repeat (32) write_kdist(POINT_W'($urandom_range(TABLE_DEPTH - 1)), random_distance());
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      wait_idle();
      write_neighbor_count(PHASE_K[phase]);
      if (phase < 4) begin
        tx_idle_pct  <= 14;
        rx_stall_pct <= 48;
      end else if (phase < 8) begin
        tx_idle_pct  <= 48;
        rx_stall_pct <= 14;
      end else begin
        tx_idle_pct  <= 0;
        rx_stall_pct <= 0;
      end
      @(posedge clk);
      // receiver holds off while items keep coming, so the queue fills up
      if (phase == 1) begin
        fork
          hold_receiver();
          run_random(PHASE_ITEMS);
        join
      end else begin
        run_random(PHASE_ITEMS);
      end
    end
    wait_idle();
    if (tracker.mismatches == 0 && tracker.expected_scores.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
